### hdl/adx_pkg.sv
// ---------------------------------------------------------------------------
// adx_pkg
// Shared types and constants for the average directional index filter.
// ---------------------------------------------------------------------------
package adx_pkg;

  localparam int PRICE_WIDTH_DEF = 32;
  localparam int SUM_W = 40;
  localparam int IDX_W = 23;
  localparam int CNT_W = 10;
  localparam int DIV_W = 64;
  localparam logic [IDX_W-1:0] HUNDRED_Q16 = IDX_W'(6553600);
  localparam logic [7:0] PERIOD_RESET = 8'd14;

  typedef struct packed {
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic [31:0] close_price;
    logic        series_start;
  } adx_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_value;
    logic             index_valid;
  } adx_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV_SR, ST_DIV_SP, ST_DIV_SM, ST_UPD, ST_DI,
    ST_DIV_PDI, ST_DIV_MDI, ST_DX, ST_DIV_DX, ST_AVG_MUL, ST_DIV_AVG,
    ST_DONE, ST_OUT
  } adx_state_t;

  typedef enum logic [2:0] {
    DSEL_SR, DSEL_SP, DSEL_SM, DSEL_PDI, DSEL_MDI, DSEL_DX, DSEL_AVG
  } adx_dsel_t;

  typedef struct packed {
    logic      load_in;
    logic      prep;
    logic      div_start;
    adx_dsel_t div_sel;
    logic      div_store;
    logic      update_sums;
    logic      make_dx;
    logic      finish;
    logic      out_load;
  } adx_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_sums;
    logic need_index;
    logic dx_div;
  } adx_stat_t;

endpackage

### hdl/adx_div.sv
// ---------------------------------------------------------------------------
// adx_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module adx_div import adx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  logic [DIV_W-1:0] rem, dvs;
  logic [6:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   trial;

  assign trial = {rem, quotient[DIV_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
        cnt      <= 7'(DIV_W);
      end else if (busy) begin
        if (trial[DIV_W]) begin
          rem      <= {rem[DIV_W-2:0], quotient[DIV_W-1]};
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end else begin
          rem      <= trial[DIV_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/adx_ctrl.sv
// ---------------------------------------------------------------------------
// adx_ctrl
// Sequencer for one bar: sums, DI, DX and ADX through the shared divider.
// ---------------------------------------------------------------------------
module adx_ctrl import adx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  adx_stat_t stat,
  output adx_cmd_t  cmd
);
  adx_state_t state, state_next;
  logic pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DSEL_SR;
    in_ready   = 1'b0;
    pend_next  = pend;
    if (out_ready) pend_next = 1'b0;
    out_valid  = pend;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = stat.need_sums ? ST_DIV_SR : ST_DONE;
        if (stat.need_sums) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_SR;
        end
      end
      ST_DIV_SR, ST_DIV_SP, ST_DIV_SM, ST_DIV_PDI, ST_DIV_MDI, ST_DIV_DX,
      ST_DIV_AVG: begin
        case (state)
          ST_DIV_SR:  cmd.div_sel = DSEL_SR;
          ST_DIV_SP:  cmd.div_sel = DSEL_SP;
          ST_DIV_SM:  cmd.div_sel = DSEL_SM;
          ST_DIV_PDI: cmd.div_sel = DSEL_PDI;
          ST_DIV_MDI: cmd.div_sel = DSEL_MDI;
          ST_DIV_DX:  cmd.div_sel = DSEL_DX;
          default:    cmd.div_sel = DSEL_AVG;
        endcase
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          case (state)
            ST_DIV_SR: begin
              cmd.div_start = 1'b1;
              state_next = ST_DIV_SP;
            end
            ST_DIV_SP: begin
              cmd.div_start = 1'b1;
              state_next = ST_DIV_SM;
            end
            ST_DIV_SM:  state_next = ST_UPD;
            ST_DIV_PDI: begin
              cmd.div_start = 1'b1;
              state_next = ST_DIV_MDI;
            end
            ST_DIV_MDI: state_next = ST_DX;
            ST_DIV_DX:  state_next = ST_AVG_MUL;
            default:    state_next = ST_DONE;
          endcase
          if (state == ST_DIV_SR) cmd.div_sel = DSEL_SP;
          if (state == ST_DIV_SP) cmd.div_sel = DSEL_SM;
          if (state == ST_DIV_PDI) cmd.div_sel = DSEL_MDI;
        end
      end
      ST_UPD: begin
        cmd.update_sums = 1'b1;
        state_next = ST_DI;
      end
      ST_DI: begin
        state_next = ST_DONE;
        if (stat.need_index) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_PDI;
          state_next    = ST_DIV_PDI;
        end
      end
      ST_DX: begin
        cmd.make_dx = 1'b1;
        state_next  = ST_AVG_MUL;
        if (stat.dx_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_DX;
          state_next    = ST_DIV_DX;
        end
      end
      ST_AVG_MUL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_AVG;
        state_next    = ST_DIV_AVG;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!pend || out_ready) begin
          cmd.out_load = 1'b1;
          pend_next    = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

### hdl/adx_dp.sv
// ---------------------------------------------------------------------------
// adx_dp
// Bar registers, Wilder sums, DI/DX/ADX arithmetic around one divider.
// ---------------------------------------------------------------------------
module adx_dp import adx_pkg::*; #(
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  adx_in_t   in_item,
  input  logic [7:0] period_reg,
  input  adx_cmd_t  cmd,
  output adx_stat_t stat,
  output adx_out_t  out_item
);
  localparam int PW = PRICE_WIDTH;
  localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

  logic [PW-1:0]    cur_h, cur_l, cur_c, last_high, last_low, last_close;
  logic [CNT_W-1:0] bar_count, t, t_cur;
  logic [SUM_W-1:0] s_r, s_p, s_m;
  logic [SUM_W-1:0] q_r, q_p, q_m;
  logic [PW:0]      trv, pdm, mdm;
  logic [IDX_W-1:0] directional_average, pdi, mdi, dx;
  logic             average_seeded, valid, cur_start;
  logic [7:0]       p;
  logic [CNT_W-1:0] limit;
  logic [DIV_W-1:0] dvd, dvs, quo;
  logic             div_done;
  logic             stat_store_avg, store_dx, store_q_r, store_q_p, store_q_m;
  logic             store_pdi, store_mdi;
  adx_dsel_t        last_sel;

  assign p     = (period_reg < 8'd2) ? 8'd2 : period_reg;
  assign limit = CNT_W'({p, 1'b0}) + CNT_W'(2);
  assign t_cur = cur_start ? '0 : ((bar_count > limit) ? limit : bar_count);

  logic signed [PW+1:0] shi, slo, sph, spl, spc, tr0, ta, tb, up, dn;
  always_comb begin
    shi = (PW+2)'(cur_h);
    slo = (PW+2)'(cur_l);
    sph = (PW+2)'(last_high);
    spl = (PW+2)'(last_low);
    spc = (PW+2)'(last_close);
    tr0 = shi - slo;
    ta  = shi - spc;
    if (ta < 0) ta = -ta;
    tb  = slo - spc;
    if (tb < 0) tb = -tb;
    if (ta > tr0) tr0 = ta;
    if (tb > tr0) tr0 = tb;
    up = shi - sph;
    dn = spl - slo;
    trv = tr0[PW:0];
    pdm = (up > dn && up > 0) ? up[PW:0] : '0;
    mdm = (dn > up && dn > 0) ? dn[PW:0] : '0;
  end

  function automatic logic [SUM_W-1:0] sat(input logic [SUM_W:0] v);
    return (v > SUM_MAX) ? {SUM_W{1'b1}} : v[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] wil(input logic [SUM_W-1:0] s,
                                           input logic [SUM_W-1:0] q,
                                           input logic [PW:0] a);
    return sat({1'b0, s - q} + (SUM_W+1)'(a));
  endfunction

  logic [IDX_W:0]   disum;
  logic [IDX_W-1:0] didiff;
  assign disum  = {1'b0, pdi} + {1'b0, mdi};
  assign didiff = (pdi > mdi) ? pdi - mdi : mdi - pdi;

  always_comb begin
    dvd = '0;
    dvs = DIV_W'(p);
    case (cmd.div_sel)
      DSEL_SR: dvd = DIV_W'(s_r);
      DSEL_SP: dvd = DIV_W'(s_p);
      DSEL_SM: dvd = DIV_W'(s_m);
      DSEL_PDI: begin
        dvd = DIV_W'(s_p) * DIV_W'(HUNDRED_Q16);
        dvs = DIV_W'(s_r);
      end
      DSEL_MDI: begin
        dvd = DIV_W'(s_m) * DIV_W'(HUNDRED_Q16);
        dvs = DIV_W'(s_r);
      end
      DSEL_DX: begin
        dvd = DIV_W'(didiff) * DIV_W'(HUNDRED_Q16);
        dvs = DIV_W'(disum);
      end
      DSEL_AVG: dvd = DIV_W'(directional_average) * DIV_W'(p - 8'd1) + DIV_W'(dx);
      default: dvd = '0;
    endcase
  end

  adx_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dvd),
    .divisor(dvs), .done(div_done), .quotient(quo)
  );

  function automatic logic [IDX_W-1:0] di_sat(input logic [DIV_W-1:0] q);
    return (q > DIV_W'(HUNDRED_Q16)) ? HUNDRED_Q16 : q[IDX_W-1:0];
  endfunction

  assign stat.div_done   = div_done;
  assign stat.need_sums  = (t_cur >= CNT_W'(1));
  assign stat.need_index = (t >= CNT_W'(2)) && (s_r != '0);
  assign stat.dx_div     = (disum != '0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) last_sel <= cmd.div_sel;
  end
  assign store_q_r = cmd.div_store && last_sel == DSEL_SR;
  assign store_q_p = cmd.div_store && last_sel == DSEL_SP;
  assign store_q_m = cmd.div_store && last_sel == DSEL_SM;
  assign store_pdi = cmd.div_store && last_sel == DSEL_PDI;
  assign store_mdi = cmd.div_store && last_sel == DSEL_MDI;
  assign store_dx  = cmd.div_store && last_sel == DSEL_DX;
  assign stat_store_avg = cmd.div_store && last_sel == DSEL_AVG;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_count <= '0;
      average_seeded <= 1'b0;
      directional_average <= '0;
      last_high <= '0;
      last_low <= '0;
      last_close <= '0;
      s_r <= '0;
      s_p <= '0;
      s_m <= '0;
    end else begin
      if (cmd.load_in) begin
        cur_h <= PW'(in_item.high_price);
        cur_l <= PW'(in_item.low_price);
        cur_c <= PW'(in_item.close_price);
        cur_start <= in_item.series_start;
      end
      if (cmd.prep) begin
        valid <= 1'b0;
        t <= t_cur;
        bar_count <= t_cur;
        if (cur_start) begin
          last_high <= '0;
          last_low <= '0;
          last_close <= '0;
          s_r <= '0;
          s_p <= '0;
          s_m <= '0;
          directional_average <= '0;
          average_seeded <= 1'b0;
        end
      end
      if (cmd.update_sums) begin
        if (t == CNT_W'(1)) begin
          s_r <= sat((SUM_W+1)'(trv));
          s_p <= sat((SUM_W+1)'(pdm));
          s_m <= sat((SUM_W+1)'(mdm));
        end else begin
          s_r <= wil(s_r, q_r, trv);
          s_p <= wil(s_p, q_p, pdm);
          s_m <= wil(s_m, q_m, mdm);
        end
      end
      if (cmd.make_dx) dx <= '0;
      if (cmd.finish) begin
        last_high <= cur_h;
        last_low <= cur_l;
        last_close <= cur_c;
        if (t < limit) bar_count <= t + CNT_W'(1);
        else bar_count <= t;
      end
      if (cmd.out_load) begin
        out_item.index_valid <= valid;
        out_item.index_value <= valid ? directional_average : '0;
      end
      if (stat_store_avg) begin
        if (!average_seeded) directional_average <= dx;
        else directional_average <= quo[IDX_W-1:0];
        average_seeded <= 1'b1;
        valid <= (t >= limit);
      end
      if (store_dx) dx <= quo[IDX_W-1:0];
      if (store_q_r) q_r <= quo[SUM_W-1:0];
      if (store_q_p) q_p <= quo[SUM_W-1:0];
      if (store_q_m) q_m <= quo[SUM_W-1:0];
      if (store_pdi) pdi <= di_sat(quo);
      if (store_mdi) mdi <= di_sat(quo);
    end
  end
endmodule

### hdl/average_directional_index_filter_core.sv
// ---------------------------------------------------------------------------
// average_directional_index_filter_core
// Wilder average directional index over a stream of price bars.
// ---------------------------------------------------------------------------
// One bar enters on the in channel (valid/ready); one result leaves on the
// out channel per bar. Bars are processed one at a time through the shared
// radix-2 divider. A first bar of a series needs no division: it goes through
// the prep, done and output steps, and the next bar can then enter. The
// second bar, or a bar with a zero smoothed range, needs 3 divisions. A full
// bar needs 7 divisions, or 6 when the sum of the two DI values is zero.
// The result register lets the next bar enter while a result waits; that
// bar then holds in its last step until the first result is taken.
// cfg_we writes the averaging period; write only while idle.
// Synchronous reset clears the series state and sets the period to 14.
// index_valid is low during warm-up (bar index below 2*period+2, counting the
// first bar of a series as 0) and while the smoothed range is zero, and
// index_value is then zero.
module average_directional_index_filter_core import adx_pkg::*; #(
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  adx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output adx_out_t out_data,
  input  logic     cfg_we,
  input  logic [7:0] cfg_data
);
  logic [7:0] period_reg;
  adx_cmd_t   cmd;
  adx_stat_t  stat;

  always_ff @(posedge clk) begin
    if (rst) period_reg <= PERIOD_RESET;
    else if (cfg_we) period_reg <= cfg_data;
  end

  adx_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .stat(stat), .cmd(cmd)
  );

  adx_dp #(.PRICE_WIDTH(PRICE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .period_reg(period_reg),
    .cmd(cmd), .stat(stat), .out_item(out_data)
  );

  a_val_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.index_valid |-> out_data.index_value <= HUNDRED_Q16)
    else $error("index out of range");
  a_inval_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.index_valid |-> out_data.index_value == '0)
    else $error("invalid result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
endmodule
